>>> rtl/color_blob_tracker_pan_tilt_macros.svh
// assertion helpers for the tracker, clocked on clk and disabled in reset
`ifndef COLOR_BLOB_TRACKER_PAN_TILT_MACROS_SVH
`define COLOR_BLOB_TRACKER_PAN_TILT_MACROS_SVH

`define CBT_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cbt_pkg.sv
package cbt_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 19;

	localparam logic [CFG_INDEX_W-1:0] REG_PIXELS_PER_LINE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LINES_PER_FRAME = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RED_LOW         = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RED_HIGH        = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GREEN_HIGH      = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_BLUE_LOW        = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_BLUE_HIGH       = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_COUNT       = 4'd7;

	localparam logic [7:0] GRAY_R_WT = 8'd54;
	localparam logic [7:0] GRAY_G_WT = 8'd183;
	localparam logic [7:0] GRAY_B_WT = 8'd19;

	localparam logic [18:0] COUNT_MAX = 19'h7FFFF;
	localparam logic [27:0] SUM_MAX   = 28'hFFFFFFF;

	localparam logic [16:0] PAN_CENTER = 17'd110100;
	localparam logic [16:0] PAN_MIN    = 17'd107100;
	localparam logic [16:0] PAN_MAX    = 17'd113100;
	localparam logic [17:0] TILT_MIN   = 18'd112600;
	localparam logic [17:0] TILT_MAX   = 18'd152100;
	localparam logic [17:0] TILT_RESET = 18'd132350;

	localparam int DIV_STEPS = 28;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [9:0]  pixels_per_line;
		logic [8:0]  lines_per_frame;
		logic [7:0]  red_low;
		logic [7:0]  red_high;
		logic [7:0]  green_high;
		logic [7:0]  blue_low;
		logic [7:0]  blue_high;
		logic [18:0] min_count;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic div_load;
		logic div_step;
		logic scale;
		logic finish;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic hit_detect;
		logic div_last;
		logic out_busy;
	} dp_status_t;

endpackage

>>> rtl/cbt_regs.sv
module cbt_regs
	import cbt_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixels_per_line <= 10'd640;
			cfg_q.lines_per_frame <= 9'd480;
			cfg_q.red_low         <= 8'd60;
			cfg_q.red_high        <= 8'd100;
			cfg_q.green_high      <= 8'd40;
			cfg_q.blue_low        <= 8'd20;
			cfg_q.blue_high       <= 8'd60;
			cfg_q.min_count       <= 19'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PIXELS_PER_LINE: cfg_q.pixels_per_line <= cfg_data[9:0];
				REG_LINES_PER_FRAME: cfg_q.lines_per_frame <= cfg_data[8:0];
				REG_RED_LOW:         cfg_q.red_low         <= cfg_data[7:0];
				REG_RED_HIGH:        cfg_q.red_high        <= cfg_data[7:0];
				REG_GREEN_HIGH:      cfg_q.green_high      <= cfg_data[7:0];
				REG_BLUE_LOW:        cfg_q.blue_low        <= cfg_data[7:0];
				REG_BLUE_HIGH:       cfg_q.blue_high       <= cfg_data[7:0];
				REG_MIN_COUNT:       cfg_q.min_count       <= cfg_data[18:0];
				default: begin
				end
			endcase
		end
	end

endmodule

>>> rtl/cbt_ctrl.sv
module cbt_ctrl
	import cbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pixel_valid,
	output logic       pixel_stall,
	input  dp_status_t sts,
	output ctrl_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV    = 2'd1;
	localparam logic [1:0] ST_SCALE  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd         = '0;
		pixel_stall = 1'b1;
		state_nxt   = state_q;
		case (state_q)
			ST_IDLE: begin
				pixel_stall  = sts.out_busy;
				cmd.take     = pixel_valid && !sts.out_busy;
				cmd.div_load = cmd.take && sts.hit_detect;
				cmd.load_out = cmd.take && !sts.hit_detect;
				if (cmd.div_load) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = ST_SCALE;
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish   = 1'b1;
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> rtl/cbt_dp.sv
module cbt_dp
	import cbt_pkg::*;
#(
	parameter int MAX_LINE_PIXELS = 640,
	parameter int MAX_FRAME_LINES = 480
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  ctrl_cmd_t   cmd,
	output dp_status_t  sts,
	input  logic [15:0] pixel,
	input  logic        result_stall,
	output logic        result_valid,
	output logic [7:0]  gray,
	output logic        frame_done,
	output logic        detected,
	output logic [8:0]  center_line,
	output logic [9:0]  center_pixel,
	output logic [16:0] pan_drive,
	output logic [17:0] tilt_drive
);

	logic [9:0]  ppl;
	logic [8:0]  lpf;
	logic [7:0]  r, g, b;
	logic [15:0] gray_sum;
	logic [7:0]  gray_pix;
	logic        match;
	logic        end_line, end_frame;

	logic [8:0]  line_q;
	logic [9:0]  col_q;
	logic [18:0] count_q, count_nxt;
	logic [27:0] line_sum_q, line_sum_nxt;
	logic [27:0] col_sum_q, col_sum_nxt;
	logic [28:0] line_sum_ext, col_sum_ext;
	logic [17:0] tilt_q, tilt_nxt;
	logic [16:0] pan_q, pan_nxt;

	logic [27:0]          dvd_line_q, dvd_col_q;
	logic [18:0]          divisor_q;
	logic [18:0]          rem_line_q, rem_col_q;
	logic [19:0]          try_line, try_col;
	logic                 ge_line, ge_col;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [7:0]           gray_hold_q;

	logic signed [35:0] diff_line, diff_col;
	logic signed [35:0] ofs_line_s1, ofs_col_s1;
	logic signed [35:0] tilt_sum, pan_sum;

	logic        result_valid_q;
	logic [7:0]  gray_q;
	logic        frame_done_q, detected_q;
	logic [8:0]  center_line_q;
	logic [9:0]  center_pixel_q;
	logic [16:0] pan_out_q;
	logic [17:0] tilt_out_q;

	// frame size, zero acts as one and large values stop at the limit
	always_comb begin
		if (cfg.pixels_per_line == '0) begin
			ppl = 10'd1;
		end else if (int'(cfg.pixels_per_line) > MAX_LINE_PIXELS) begin
			ppl = 10'(MAX_LINE_PIXELS);
		end else begin
			ppl = cfg.pixels_per_line;
		end
		if (cfg.lines_per_frame == '0) begin
			lpf = 9'd1;
		end else if (int'(cfg.lines_per_frame) > MAX_FRAME_LINES) begin
			lpf = 9'(MAX_FRAME_LINES);
		end else begin
			lpf = cfg.lines_per_frame;
		end
	end

	assign r = {pixel[15:11], 3'b000};
	assign g = {pixel[10:5], 2'b00};
	assign b = {pixel[4:0], 3'b000};

	assign gray_sum = 16'(r) * 16'(GRAY_R_WT) + 16'(g) * 16'(GRAY_G_WT)
		+ 16'(b) * 16'(GRAY_B_WT);
	assign gray_pix = gray_sum[15:8];

	assign match = (cfg.red_low < r) && (r < cfg.red_high)
		&& (g != '0) && (g < cfg.green_high)
		&& (cfg.blue_low < b) && (b < cfg.blue_high);

	assign line_sum_ext = 29'(line_sum_q) + 29'(line_q);
	assign col_sum_ext  = 29'(col_sum_q) + 29'(col_q);

	always_comb begin
		count_nxt    = count_q;
		line_sum_nxt = line_sum_q;
		col_sum_nxt  = col_sum_q;
		if (match) begin
			count_nxt    = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 19'd1;
			line_sum_nxt = line_sum_ext[28] ? SUM_MAX : line_sum_ext[27:0];
			col_sum_nxt  = col_sum_ext[28] ? SUM_MAX : col_sum_ext[27:0];
		end
	end

	assign end_line  = (11'(col_q) + 11'd1) >= 11'(ppl);
	assign end_frame = end_line && ((10'(line_q) + 10'd1) >= 10'(lpf));

	assign sts.hit_detect = end_frame && (count_nxt > cfg.min_count);
	assign sts.div_last   = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign sts.out_busy   = result_valid_q && result_stall;

	// shared restoring divider, one quotient bit per step for both sums
	assign try_line = {rem_line_q, dvd_line_q[27]};
	assign try_col  = {rem_col_q, dvd_col_q[27]};
	assign ge_line  = try_line >= {1'b0, divisor_q};
	assign ge_col   = try_col >= {1'b0, divisor_q};

	assign diff_line = $signed({8'd0, dvd_line_q}) - $signed({28'd0, lpf[8:1]});
	assign diff_col  = $signed({8'd0, dvd_col_q}) - $signed({27'd0, ppl[9:1]});

	assign tilt_sum = $signed({18'd0, tilt_q}) + ofs_line_s1;
	assign pan_sum  = $signed({19'd0, PAN_CENTER}) + ofs_col_s1;

	always_comb begin
		if (tilt_sum < $signed({18'd0, TILT_MIN})) begin
			tilt_nxt = TILT_MIN;
		end else if (tilt_sum > $signed({18'd0, TILT_MAX})) begin
			tilt_nxt = TILT_MAX;
		end else begin
			tilt_nxt = tilt_sum[17:0];
		end
		if (pan_sum < $signed({19'd0, PAN_MIN})) begin
			pan_nxt = PAN_MIN;
		end else if (pan_sum > $signed({19'd0, PAN_MAX})) begin
			pan_nxt = PAN_MAX;
		end else begin
			pan_nxt = pan_sum[16:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q         <= '0;
			col_q          <= '0;
			count_q        <= '0;
			line_sum_q     <= '0;
			col_sum_q      <= '0;
			tilt_q         <= TILT_RESET;
			pan_q          <= PAN_CENTER;
			div_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (end_frame) begin
					line_q     <= '0;
					col_q      <= '0;
					count_q    <= '0;
					line_sum_q <= '0;
					col_sum_q  <= '0;
				end else begin
					count_q    <= count_nxt;
					line_sum_q <= line_sum_nxt;
					col_sum_q  <= col_sum_nxt;
					if (end_line) begin
						col_q  <= '0;
						line_q <= line_q + 9'd1;
					end else begin
						col_q <= col_q + 10'd1;
					end
				end
			end
			if (cmd.div_load) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.finish) begin
				tilt_q <= tilt_nxt;
				pan_q  <= pan_nxt;
			end
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_line_q  <= line_sum_nxt;
			dvd_col_q   <= col_sum_nxt;
			divisor_q   <= count_nxt;
			rem_line_q  <= '0;
			rem_col_q   <= '0;
			gray_hold_q <= gray_pix;
		end else if (cmd.div_step) begin
			rem_line_q <= ge_line ? 19'(try_line - {1'b0, divisor_q}) : try_line[18:0];
			rem_col_q  <= ge_col ? 19'(try_col - {1'b0, divisor_q}) : try_col[18:0];
			dvd_line_q <= {dvd_line_q[26:0], ge_line};
			dvd_col_q  <= {dvd_col_q[26:0], ge_col};
		end
		if (cmd.scale) begin
			ofs_line_s1 <= (diff_line <<< 2) + (diff_line <<< 1);
			ofs_col_s1  <= (diff_col <<< 2) + (diff_col <<< 1);
		end
		if (cmd.load_out) begin
			if (cmd.finish) begin
				gray_q         <= gray_hold_q;
				frame_done_q   <= 1'b1;
				detected_q     <= 1'b1;
				center_line_q  <= dvd_line_q[8:0];
				center_pixel_q <= dvd_col_q[9:0];
				pan_out_q      <= pan_nxt;
				tilt_out_q     <= tilt_nxt;
			end else begin
				gray_q         <= gray_pix;
				frame_done_q   <= end_frame;
				detected_q     <= 1'b0;
				center_line_q  <= '0;
				center_pixel_q <= '0;
				pan_out_q      <= pan_q;
				tilt_out_q     <= tilt_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign gray         = gray_q;
	assign frame_done   = frame_done_q;
	assign detected     = detected_q;
	assign center_line  = center_line_q;
	assign center_pixel = center_pixel_q;
	assign pan_drive    = pan_out_q;
	assign tilt_drive   = tilt_out_q;

endmodule

>>> rtl/color_blob_tracker_pan_tilt.sv
// Color blob tracker with pan/tilt drive. Each accepted RGB565 pixel gives one result
// (gray value, frame flags, centroid, pan and tilt drive) from a single output register,
// and the next pixel is taken in the next cycle, so a stream runs at one pixel per clock
// while the result side keeps up. The last pixel of a frame whose match count exceeds
// min_count instead goes through the shared restoring divider, which forms both centroid
// coordinates one quotient bit per cycle, then a step that scales the offsets and a step
// that clamps and loads pan and tilt when the output is free; meanwhile no pixel is accepted.
// Registers are written through the configuration channel, which is always ready.
`include "color_blob_tracker_pan_tilt_macros.svh"

module color_blob_tracker_pan_tilt
	import cbt_pkg::*;
#(
	parameter int MAX_LINE_PIXELS = 640,
	parameter int MAX_FRAME_LINES = 480
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  logic [15:0]            pixel,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [7:0]             gray,
	output logic                   frame_done,
	output logic                   detected,
	output logic [8:0]             center_line,
	output logic [9:0]             center_pixel,
	output logic [16:0]            pan_drive,
	output logic [17:0]            tilt_drive
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t sts;

	cbt_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cbt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.sts         (sts),
		.cmd         (cmd)
	);

	cbt_dp #(
		.MAX_LINE_PIXELS (MAX_LINE_PIXELS),
		.MAX_FRAME_LINES (MAX_FRAME_LINES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.pixel        (pixel),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.gray         (gray),
		.frame_done   (frame_done),
		.detected     (detected),
		.center_line  (center_line),
		.center_pixel (center_pixel),
		.pan_drive    (pan_drive),
		.tilt_drive   (tilt_drive)
	);

	`CBT_ASSERT_IMPLIES(a_det_on_frame_end, result_valid && detected, frame_done, "detected without frame end")
	`CBT_ASSERT_IMPLIES(a_no_take_busy, cmd.div_step || cmd.scale, pixel_stall, "pixel taken during division")
	`CBT_ASSERT_NEXT(a_div_after_hit, cmd.div_load, cmd.div_step, "division did not start")
	`CBT_ASSERT_IMPLIES(a_pan_range, result_valid, pan_drive >= PAN_MIN && pan_drive <= PAN_MAX, "pan out of range")

endmodule
